/* rtl/plob_pkg.sv */
// ----------------------------------------------------------------------------
// plob_pkg: shared types and constants of the price level order book
// Level count, mode and status codes, cell word and per-side command.
// ----------------------------------------------------------------------------
package plob_pkg;

  localparam int NUM_LEVELS = 64;

  localparam logic [1:0] MODE_UPDATE = 2'd0;
  localparam logic [1:0] MODE_CLEAR  = 2'd1;
  localparam logic [1:0] MODE_SNAP   = 2'd2;

  localparam logic [1:0] STAT_APPLIED = 2'd0;
  localparam logic [1:0] STAT_IGNORED = 2'd1;
  localparam logic [1:0] STAT_DROPPED = 2'd2;

  // one price level as held in a cell
  typedef struct packed {
    logic        valid;
    logic [30:0] price;
    logic [30:0] qty;
  } level_t;

  // command broadcast to every cell of one side
  typedef struct packed {
    logic        clear;
    logic        ins;
    logic        del;
    logic        upd;
    logic [30:0] price;
    logic [30:0] qty;
  } cmd_t;

endpackage

/* rtl/plob_in_if.sv */
// ----------------------------------------------------------------------------
// plob_in_if: input channel of the order book
// Valid/ready handshake carrying one update word.
// ----------------------------------------------------------------------------
interface plob_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic               side;
  logic signed [31:0] price;
  logic signed [31:0] quantity;

  modport source (output valid, output mode, output side, output price,
                  output quantity, input ready);
  modport sink   (input valid, input mode, input side, input price,
                  input quantity, output ready);
endinterface

/* rtl/plob_out_if.sv */
// ----------------------------------------------------------------------------
// plob_out_if: result channel of the order book
// Valid/ready handshake carrying status and top of book.
// ----------------------------------------------------------------------------
interface plob_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic               bid_valid;
  logic [30:0]        best_bid_price;
  logic [30:0]        best_bid_qty;
  logic               ask_valid;
  logic [30:0]        best_ask_price;
  logic [30:0]        best_ask_qty;
  logic signed [31:0] spread;
  logic [30:0]        mid_price;

  modport source (output valid, output status, output bid_valid,
                  output best_bid_price, output best_bid_qty, output ask_valid,
                  output best_ask_price, output best_ask_qty, output spread,
                  output mid_price, input ready);
  modport sink   (input valid, input status, input bid_valid,
                  input best_bid_price, input best_bid_qty, input ask_valid,
                  input best_ask_price, input best_ask_qty, input spread,
                  input mid_price, output ready);
endinterface

/* rtl/plob_cell.sv */
// ----------------------------------------------------------------------------
// plob_cell: one price level slot of a sorted side
// Compares its level with the broadcast price and shifts with its neighbors.
// ----------------------------------------------------------------------------
module plob_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            is_ask,
  input  plob_pkg::cmd_t  cmd,
  input  plob_pkg::level_t left_lvl,
  input  logic            left_before,
  input  plob_pkg::level_t right_lvl,
  output plob_pkg::level_t lvl,
  output logic            ahead,
  output logic            match
);

  plob_pkg::level_t lvl_r, lvl_nxt;

  assign lvl    = lvl_r;
  assign match  = lvl_r.valid && (lvl_r.price == cmd.price);
  // this level ranks ahead of the incoming price
  assign ahead  = lvl_r.valid &&
                  (is_ask ? (lvl_r.price < cmd.price) : (lvl_r.price > cmd.price));

  always_comb begin
    lvl_nxt = lvl_r;
    priority if (cmd.clear) begin
      lvl_nxt.valid = 1'b0;
    end else if (cmd.upd) begin
      if (match) begin
        lvl_nxt.qty = cmd.qty;
      end
    end else if (cmd.ins) begin
      if (!ahead) begin
        if (left_before) begin
          lvl_nxt.valid = 1'b1;
          lvl_nxt.price = cmd.price;
          lvl_nxt.qty   = cmd.qty;
        end else begin
          lvl_nxt = left_lvl;
        end
      end
    end else if (cmd.del) begin
      // close the gap from the matching level onward
      if (!ahead) begin
        lvl_nxt = right_lvl;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lvl_r.valid <= 1'b0;
    end else begin
      lvl_r.valid <= lvl_nxt.valid;
    end
    lvl_r.price <= lvl_nxt.price;
    lvl_r.qty   <= lvl_nxt.qty;
  end

endmodule

/* rtl/plob_chain.sv */
// ----------------------------------------------------------------------------
// plob_chain: one side of the book as a row of level cells
// Best level sits in cell zero; reports head, match and full flags.
// ----------------------------------------------------------------------------
module plob_chain (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             is_ask,
  input  plob_pkg::cmd_t   cmd,
  output plob_pkg::level_t head,
  output logic             any_match,
  output logic             full
);

  localparam int N = plob_pkg::NUM_LEVELS;

  plob_pkg::level_t lvl    [N];
  plob_pkg::level_t left_l [N];
  plob_pkg::level_t right_l[N];
  logic [N-1:0]     before_v;
  logic [N-1:0]     match_v;
  logic [N-1:0]     left_b;

  genvar g;
  generate
    for (g = 0; g < N; g++) begin : g_cell
      if (g == 0) begin : g_first
        assign left_l[g] = '0;
        assign left_b[g] = 1'b1;
      end else begin : g_mid
        assign left_l[g] = lvl[g-1];
        assign left_b[g] = before_v[g-1];
      end
      if (g == N - 1) begin : g_last
        assign right_l[g] = '0;
      end else begin : g_inner
        assign right_l[g] = lvl[g+1];
      end

      plob_cell u_cell (
        .clk         (clk),
        .rst_n       (rst_n),
        .is_ask      (is_ask),
        .cmd         (cmd),
        .left_lvl    (left_l[g]),
        .left_before (left_b[g]),
        .right_lvl   (right_l[g]),
        .lvl         (lvl[g]),
        .ahead       (before_v[g]),
        .match       (match_v[g])
      );
    end
  endgenerate

  assign head      = lvl[0];
  assign any_match = |match_v;
  assign full      = lvl[N-1].valid;

endmodule

/* rtl/price_level_order_book.sv */
// ----------------------------------------------------------------------------
// price_level_order_book: aggregated bid/ask price level book
// Two sorted cell rows with top-of-book, spread and mid price reporting.
// ----------------------------------------------------------------------------
// Each side is a row of plob_pkg::NUM_LEVELS cells kept sorted best first;
// an update is compared against every cell at once and the row inserts,
// removes or rewrites a level in a single shift step. A word passes through
// an execute state, in which the cells compare and shift, and a response
// state, in which top of book, spread and mid price are formed from cell
// zero of each row and loaded into the output register. The next word is
// taken in that response state while the output side keeps up; a result
// waiting in the output register holds the block in its response state.
// No clearing pass is needed after reset: every cell's valid flag clears at
// once.
// ----------------------------------------------------------------------------
module price_level_order_book (
  input  logic       clk,
  input  logic       rst_n,
  plob_in_if.sink    in_ch,
  plob_out_if.source out_ch
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_RESP = 2'd2;

  logic [1:0]  state_r, state_nxt;
  logic [1:0]  mode_r;
  logic        side_r;
  logic [31:0] price_r;
  logic [31:0] qty_r;
  logic [1:0]  status_r, status_nxt;

  logic               out_valid_r;
  logic [1:0]         out_status_r;
  logic               out_bv_r, out_av_r;
  logic [30:0]        out_bp_r, out_bq_r, out_ap_r, out_aq_r, out_mid_r;
  logic signed [31:0] out_spread_r;

  plob_pkg::cmd_t   bid_cmd, ask_cmd;
  plob_pkg::level_t bid_head, ask_head;
  logic             bid_match, ask_match, bid_full, ask_full;

  logic p_pos, q_neg, q_zero, set_ok, sel_match, sel_full, exec;
  logic out_free, in_acc, load;
  logic [30:0] bp, bq, ap, aq;
  logic [31:0] sum, spread_c;

  assign out_free = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE) || ((state_r == S_RESP) && out_free);
  assign in_acc = in_ch.valid && in_ch.ready;
  assign load   = (state_r == S_RESP) && out_free;
  assign exec   = (state_r == S_EXEC);

  // decode the held word
  assign p_pos  = (price_r != 32'd0) && !price_r[31];
  assign q_neg  = qty_r[31];
  assign q_zero = (qty_r == 32'd0);
  assign set_ok = p_pos && !q_neg &&
                  ((mode_r == plob_pkg::MODE_UPDATE) ||
                   ((mode_r == plob_pkg::MODE_SNAP) && !q_zero));
  assign sel_match = side_r ? ask_match : bid_match;
  assign sel_full  = side_r ? ask_full  : bid_full;

  always_comb begin
    bid_cmd       = '0;
    bid_cmd.price = price_r[30:0];
    bid_cmd.qty   = qty_r[30:0];
    bid_cmd.clear = exec && (mode_r == plob_pkg::MODE_CLEAR);
    ask_cmd       = bid_cmd;
    bid_cmd.upd   = exec && set_ok && !side_r && bid_match && !q_zero;
    bid_cmd.del   = exec && set_ok && !side_r && bid_match && q_zero;
    bid_cmd.ins   = exec && set_ok && !side_r && !bid_match && !q_zero && !bid_full;
    ask_cmd.upd   = exec && set_ok && side_r && ask_match && !q_zero;
    ask_cmd.del   = exec && set_ok && side_r && ask_match && q_zero;
    ask_cmd.ins   = exec && set_ok && side_r && !ask_match && !q_zero && !ask_full;
  end

  always_comb begin
    priority if (mode_r == plob_pkg::MODE_CLEAR) begin
      status_nxt = plob_pkg::STAT_APPLIED;
    end else if (!set_ok) begin
      status_nxt = plob_pkg::STAT_IGNORED;
    end else if (!sel_match && !q_zero && sel_full) begin
      status_nxt = plob_pkg::STAT_DROPPED;
    end else begin
      status_nxt = plob_pkg::STAT_APPLIED;
    end
  end

  plob_chain u_bid (
    .clk       (clk),
    .rst_n     (rst_n),
    .is_ask    (1'b0),
    .cmd       (bid_cmd),
    .head      (bid_head),
    .any_match (bid_match),
    .full      (bid_full)
  );

  plob_chain u_ask (
    .clk       (clk),
    .rst_n     (rst_n),
    .is_ask    (1'b1),
    .cmd       (ask_cmd),
    .head      (ask_head),
    .any_match (ask_match),
    .full      (ask_full)
  );

  // top of book from the settled rows
  assign bp       = bid_head.valid ? bid_head.price : 31'd0;
  assign bq       = bid_head.valid ? bid_head.qty   : 31'd0;
  assign ap       = ask_head.valid ? ask_head.price : 31'd0;
  assign aq       = ask_head.valid ? ask_head.qty   : 31'd0;
  assign sum      = {1'b0, ap} + {1'b0, bp};
  assign spread_c = {1'b0, ap} - {1'b0, bp};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_acc) state_nxt = S_EXEC;
      S_EXEC:  state_nxt = S_RESP;
      S_RESP:  if (out_free) state_nxt = in_acc ? S_EXEC : S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      mode_r  <= in_ch.mode;
      side_r  <= in_ch.side;
      price_r <= in_ch.price;
      qty_r   <= in_ch.quantity;
    end
    if (exec) begin
      status_r <= status_nxt;
    end
    if (load) begin
      out_status_r <= status_r;
      out_bv_r     <= bid_head.valid;
      out_av_r     <= ask_head.valid;
      out_bp_r     <= bp;
      out_bq_r     <= bq;
      out_ap_r     <= ap;
      out_aq_r     <= aq;
      out_spread_r <= (bid_head.valid && ask_head.valid) ? spread_c : 32'sd0;
      out_mid_r    <= (bid_head.valid && ask_head.valid) ? sum[31:1] : 31'd0;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = out_status_r;
  assign out_ch.bid_valid      = out_bv_r;
  assign out_ch.best_bid_price = out_bp_r;
  assign out_ch.best_bid_qty   = out_bq_r;
  assign out_ch.ask_valid      = out_av_r;
  assign out_ch.best_ask_price = out_ap_r;
  assign out_ch.best_ask_qty   = out_aq_r;
  assign out_ch.spread         = out_spread_r;
  assign out_ch.mid_price      = out_mid_r;

endmodule
